// File: hdl/jdtm_pkg.sv
// jdtm_pkg: shared types and constants for the jtag debug transport module
// no dependencies; imported by every module of the block
`default_nettype none

package jdtm_pkg;

   localparam int ADDR_BITS_DEFAULT = 7;
   localparam int IR_BITS_DEFAULT   = 5;

   localparam int DATA_W     = 32;
   localparam int OUT_ADDR_W = 7;
   localparam int CSR_IDX_W  = 1;

   localparam logic [7:0] INS_IDCODE = 8'h01;
   localparam logic [7:0] INS_DTMCS  = 8'h10;
   localparam logic [7:0] INS_DMI    = 8'h11;
   localparam logic [7:0] IR_CAPTURE = 8'h05;

   localparam logic [DATA_W-1:0] IDCODE_RESET = 32'h04F5484D;
   localparam logic [DATA_W-1:0] DTMCS_RESET  = 32'h00000071;

   localparam logic [CSR_IDX_W-1:0] CSR_IDCODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DTMCS  = 1'b1;

   localparam logic [1:0] DMI_OP_NOP = 2'd0;

   typedef enum logic [1:0] {
      KIND_PIN   = 2'd0,
      KIND_RESET = 2'd1,
      KIND_BUS   = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      TAP_TLR   = 4'd0,
      TAP_RTI   = 4'd1,
      TAP_SELDR = 4'd2,
      TAP_CAPDR = 4'd3,
      TAP_SHDR  = 4'd4,
      TAP_EX1DR = 4'd5,
      TAP_PDR   = 4'd6,
      TAP_EX2DR = 4'd7,
      TAP_UPDR  = 4'd8,
      TAP_SELIR = 4'd9,
      TAP_CAPIR = 4'd10,
      TAP_SHIR  = 4'd11,
      TAP_EX1IR = 4'd12,
      TAP_PIR   = 4'd13,
      TAP_EX2IR = 4'd14,
      TAP_UPIR  = 4'd15
   } tap_state_type;

   typedef struct packed {
      logic in_tlr;
      logic in_rti;
      logic in_capdr;
      logic in_shdr;
      logic in_updr;
      logic in_capir;
      logic in_shir;
      logic in_upir;
   } tap_ctrl_type;

   typedef struct packed {
      logic                  tdo;
      logic                  bus_req_valid;
      logic [OUT_ADDR_W-1:0] bus_req_addr;
      logic [1:0]            bus_req_op;
      logic [DATA_W-1:0]     bus_req_data;
      logic                  bus_rsp_ready;
      logic                  debug_reset_n;
      logic                  command_done;
      logic                  accepting;
   } rsp_payload_type;

endpackage

`default_nettype wire

// File: hdl/jdtm_tap_fsm.sv
// jdtm_tap_fsm: 16-state jtag tap controller with current-state decode
// depends on jdtm_pkg
`default_nettype none

module jdtm_tap_fsm (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic                  tms,
   input  wire logic                  force_rti,
   output jdtm_pkg::tap_ctrl_type     ctrl
);
   import jdtm_pkg::*;

   tap_state_type tap_state_ff;
   tap_state_type tap_state_in;

   always_comb begin
      tap_state_in = tap_state_ff;
      if (force_rti) begin
         tap_state_in = TAP_RTI;
      end else if (step) begin
         unique case (tap_state_ff)
            TAP_TLR:   tap_state_in = tms ? TAP_TLR   : TAP_RTI;
            TAP_RTI:   tap_state_in = tms ? TAP_SELDR : TAP_RTI;
            TAP_SELDR: tap_state_in = tms ? TAP_SELIR : TAP_CAPDR;
            TAP_CAPDR: tap_state_in = tms ? TAP_EX1DR : TAP_SHDR;
            TAP_SHDR:  tap_state_in = tms ? TAP_EX1DR : TAP_SHDR;
            TAP_EX1DR: tap_state_in = tms ? TAP_UPDR  : TAP_PDR;
            TAP_PDR:   tap_state_in = tms ? TAP_EX2DR : TAP_PDR;
            TAP_EX2DR: tap_state_in = tms ? TAP_UPDR  : TAP_SHDR;
            TAP_UPDR:  tap_state_in = tms ? TAP_SELDR : TAP_RTI;
            TAP_SELIR: tap_state_in = tms ? TAP_TLR   : TAP_CAPIR;
            TAP_CAPIR: tap_state_in = tms ? TAP_EX1IR : TAP_SHIR;
            TAP_SHIR:  tap_state_in = tms ? TAP_EX1IR : TAP_SHIR;
            TAP_EX1IR: tap_state_in = tms ? TAP_UPIR  : TAP_PIR;
            TAP_PIR:   tap_state_in = tms ? TAP_EX2IR : TAP_PIR;
            TAP_EX2IR: tap_state_in = tms ? TAP_UPIR  : TAP_SHIR;
            TAP_UPIR:  tap_state_in = tms ? TAP_SELDR : TAP_RTI;
            default:   tap_state_in = TAP_TLR;
         endcase
      end
   end

   always_comb begin
      ctrl = '0;
      unique case (tap_state_ff)
         TAP_TLR:   ctrl.in_tlr   = 1'b1;
         TAP_RTI:   ctrl.in_rti   = 1'b1;
         TAP_CAPDR: ctrl.in_capdr = 1'b1;
         TAP_SHDR:  ctrl.in_shdr  = 1'b1;
         TAP_UPDR:  ctrl.in_updr  = 1'b1;
         TAP_CAPIR: ctrl.in_capir = 1'b1;
         TAP_SHIR:  ctrl.in_shir  = 1'b1;
         TAP_UPIR:  ctrl.in_upir  = 1'b1;
         default:   ctrl          = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_state_ff <= TAP_TLR;
      end else begin
         tap_state_ff <= tap_state_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/jdtm_dtm.sv
// jdtm_dtm: instruction/data registers, dmi request logic and config registers
// depends on jdtm_pkg and jdtm_tap_fsm
`default_nettype none

module jdtm_dtm #(
   parameter int ADDR_BITS = jdtm_pkg::ADDR_BITS_DEFAULT,
   parameter int IR_BITS   = jdtm_pkg::IR_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               accept,
   input  wire logic [1:0]                         kind,
   input  wire logic                               tck,
   input  wire logic                               tms,
   input  wire logic                               tdi,
   input  wire logic                               trst,
   input  wire logic                               bus_req_ready,
   input  wire logic                               bus_rsp_valid,
   input  wire logic [jdtm_pkg::DATA_W-1:0]        bus_rsp_data,
   input  wire logic [1:0]                         bus_rsp_code,
   input  wire logic                               csr_write_en,
   input  wire logic [jdtm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [jdtm_pkg::DATA_W-1:0]        csr_wdata,
   output jdtm_pkg::rsp_payload_type               payload,
   output logic                                    outstanding
);
   import jdtm_pkg::*;

   localparam int DMI_LEN = 34 + ADDR_BITS;
   localparam int LEN_W   = $clog2(DMI_LEN + 1);

   logic [DATA_W-1:0]    idcode_ff, idcode_in;
   logic [DATA_W-1:0]    dtmcs_ff, dtmcs_in;
   logic [IR_BITS-1:0]   instr_shift_ff, instr_shift_in;
   logic [IR_BITS-1:0]   instr_cur_ff, instr_cur_in;
   logic [DMI_LEN-1:0]   data_shift_ff, data_shift_in;
   logic [DMI_LEN-1:0]   data_cap_ff, data_cap_in;
   logic [LEN_W-1:0]     data_len_ff, data_len_in;
   logic                 tdo_ff, tdo_in;
   logic                 outstanding_ff, outstanding_in;
   logic                 req_valid_ff, req_valid_in;
   logic [ADDR_BITS-1:0] req_addr_ff, req_addr_in;
   logic [1:0]           req_op_ff, req_op_in;
   logic [DATA_W-1:0]    req_data_ff, req_data_in;
   logic                 reset_n_ff, reset_n_in;

   logic                 pin_ok;
   logic                 step;
   logic                 rst_cmd;
   logic                 bus_sample;
   logic                 done;
   logic [DMI_LEN-1:0]   shifted;
   logic [ADDR_BITS+OUT_ADDR_W-1:0] addr_wide;
   tap_ctrl_type         ctrl;

   assign pin_ok     = accept && (kind == KIND_PIN) && !outstanding_ff;
   assign step       = pin_ok && tck;
   assign rst_cmd    = accept && (kind == KIND_RESET) && !outstanding_ff;
   assign bus_sample = accept && (kind == KIND_BUS);

   jdtm_tap_fsm u_tap_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .tms       (tms),
      .force_rti (rst_cmd && trst),
      .ctrl      (ctrl)
   );

   // shift right, tdi enters just above the captured length
   always_comb begin
      for (int i = 0; i < DMI_LEN; i++) begin
         shifted[i] = (data_len_ff == LEN_W'(i + 1)) ? tdi : 1'b0;
         if (i + 1 < DMI_LEN) begin
            shifted[i] = shifted[i] | data_shift_ff[i + 1];
         end
      end
   end

   always_comb begin
      idcode_in      = idcode_ff;
      dtmcs_in       = dtmcs_ff;
      instr_shift_in = instr_shift_ff;
      instr_cur_in   = instr_cur_ff;
      data_shift_in  = data_shift_ff;
      data_cap_in    = data_cap_ff;
      data_len_in    = data_len_ff;
      tdo_in         = tdo_ff;
      outstanding_in = outstanding_ff;
      req_valid_in   = req_valid_ff;
      req_addr_in    = req_addr_ff;
      req_op_in      = req_op_ff;
      req_data_in    = req_data_ff;
      reset_n_in     = reset_n_ff;
      done           = 1'b0;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_IDCODE: idcode_in = csr_wdata;
            CSR_DTMCS:  dtmcs_in  = csr_wdata;
         endcase
      end

      if (pin_ok && !tck) begin
         tdo_in = ctrl.in_shdr ? data_shift_ff[0] : instr_shift_ff[0];
      end

      if (step) begin
         if (ctrl.in_tlr) begin
            reset_n_in   = 1'b0;
            instr_cur_in = IR_BITS'(INS_IDCODE);
            done         = 1'b1;
         end
         if (ctrl.in_rti) begin
            reset_n_in = 1'b1;
         end
         if (ctrl.in_capdr) begin
            case (instr_cur_ff)
               IR_BITS'(INS_IDCODE): begin
                  data_shift_in = DMI_LEN'(idcode_ff);
                  data_len_in   = LEN_W'(DATA_W);
               end
               IR_BITS'(INS_DTMCS): begin
                  data_shift_in = DMI_LEN'(dtmcs_ff);
                  data_len_in   = LEN_W'(DATA_W);
               end
               IR_BITS'(INS_DMI): begin
                  data_shift_in = data_cap_ff;
                  data_len_in   = LEN_W'(DMI_LEN);
               end
               default: begin
                  data_shift_in = '0;
                  data_len_in   = LEN_W'(1);
               end
            endcase
         end
         if (ctrl.in_shdr) begin
            data_shift_in = shifted;
         end
         if (ctrl.in_updr) begin
            data_cap_in = data_shift_ff;
            if ((instr_cur_ff == IR_BITS'(INS_DMI)) && (data_shift_ff[1:0] != DMI_OP_NOP)) begin
               outstanding_in = 1'b1;
               req_valid_in   = 1'b1;
               req_addr_in    = data_shift_ff[DMI_LEN-1:34];
               req_op_in      = data_shift_ff[1:0];
               req_data_in    = data_shift_ff[33:2];
               done           = 1'b1;
            end
         end
         if (ctrl.in_capir) begin
            instr_shift_in = IR_BITS'(IR_CAPTURE);
         end
         if (ctrl.in_shir) begin
            instr_shift_in = {tdi, instr_shift_ff[IR_BITS-1:1]};
         end
         if (ctrl.in_upir) begin
            instr_cur_in = instr_shift_ff;
         end
      end

      if (rst_cmd) begin
         if (trst) begin
            reset_n_in = 1'b0;
         end
         done = 1'b1;
      end

      if (bus_sample) begin
         if (bus_req_ready) begin
            req_valid_in = 1'b0;
         end
         if (bus_rsp_valid) begin
            data_cap_in    = DMI_LEN'({bus_rsp_data, bus_rsp_code});
            outstanding_in = 1'b0;
         end
      end
   end

   assign addr_wide = {{OUT_ADDR_W{1'b0}}, req_addr_in};

   always_comb begin
      payload.tdo           = tdo_in;
      payload.bus_req_valid = req_valid_in;
      payload.bus_req_addr  = addr_wide[OUT_ADDR_W-1:0];
      payload.bus_req_op    = req_op_in;
      payload.bus_req_data  = req_data_in;
      payload.bus_rsp_ready = 1'b1;
      payload.debug_reset_n = reset_n_in;
      payload.command_done  = done;
      payload.accepting     = !outstanding_in;
   end

   assign outstanding = outstanding_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idcode_ff      <= IDCODE_RESET;
         dtmcs_ff       <= DTMCS_RESET;
         instr_shift_ff <= '0;
         instr_cur_ff   <= '0;
         data_shift_ff  <= '0;
         data_cap_ff    <= '0;
         data_len_ff    <= '0;
         tdo_ff         <= 1'b0;
         outstanding_ff <= 1'b0;
         req_valid_ff   <= 1'b0;
         req_addr_ff    <= '0;
         req_op_ff      <= '0;
         req_data_ff    <= '0;
         reset_n_ff     <= 1'b0;
      end else begin
         idcode_ff      <= idcode_in;
         dtmcs_ff       <= dtmcs_in;
         instr_shift_ff <= instr_shift_in;
         instr_cur_ff   <= instr_cur_in;
         data_shift_ff  <= data_shift_in;
         data_cap_ff    <= data_cap_in;
         data_len_ff    <= data_len_in;
         tdo_ff         <= tdo_in;
         outstanding_ff <= outstanding_in;
         req_valid_ff   <= req_valid_in;
         req_addr_ff    <= req_addr_in;
         req_op_ff      <= req_op_in;
         req_data_ff    <= req_data_in;
         reset_n_ff     <= reset_n_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/jdtm_out_buf.sv
// jdtm_out_buf: result register with one skid entry behind it
// depends on jdtm_pkg
`default_nettype none

module jdtm_out_buf (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  jdtm_pkg::rsp_payload_type      push_data,
   output logic                           push_ready,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output jdtm_pkg::rsp_payload_type      out_data
);
   import jdtm_pkg::*;

   logic            main_valid_ff;
   logic            skid_valid_ff;
   rsp_payload_type main_ff;
   rsp_payload_type skid_ff;
   logic            pop;

   assign pop        = main_valid_ff && out_ready;
   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         main_ff <= skid_valid_ff ? skid_ff : push_data;
      end else if (push && !main_valid_ff) begin
         main_ff <= push_data;
      end
      if (push && main_valid_ff && !pop) begin
         skid_ff <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: hdl/jtag_debug_transport_module.sv
// jtag_debug_transport_module: top level of the jtag tap and debug transport module
// depends on jdtm_pkg, jdtm_dtm, jdtm_tap_fsm and jdtm_out_buf
`default_nettype none

// One request of any kind is taken per clock cycle while req_ready is high, and
// each gives one result. The tap step, register shift and dmi request update all
// settle combinationally from the state registers into a result register. A one
// entry skid buffer behind it still takes a request in a cycle where rsp_ready
// is low; req_ready then stays low until a pop drains the skid entry into the
// result register, and throughput is one request per cycle while rsp_ready stays
// high. Pin and test-reset requests that arrive while a dmi request is
// outstanding are taken but have no effect.
module jtag_debug_transport_module #(
   parameter int ADDR_BITS = jdtm_pkg::ADDR_BITS_DEFAULT,
   parameter int IR_BITS   = jdtm_pkg::IR_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [1:0]                         req_kind,
   input  wire logic                               req_tck,
   input  wire logic                               req_tms,
   input  wire logic                               req_tdi,
   input  wire logic                               req_trst,
   input  wire logic                               req_req_ready,
   input  wire logic                               req_rsp_valid,
   input  wire logic [jdtm_pkg::DATA_W-1:0]        req_rsp_data,
   input  wire logic [1:0]                         req_rsp_code,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_tdo,
   output logic                                    rsp_bus_req_valid,
   output logic [jdtm_pkg::OUT_ADDR_W-1:0]         rsp_bus_req_addr,
   output logic [1:0]                              rsp_bus_req_op,
   output logic [jdtm_pkg::DATA_W-1:0]             rsp_bus_req_data,
   output logic                                    rsp_bus_rsp_ready,
   output logic                                    rsp_debug_reset_n,
   output logic                                    rsp_command_done,
   output logic                                    rsp_accepting,
   input  wire logic                               csr_write_en,
   input  wire logic [jdtm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [jdtm_pkg::DATA_W-1:0]        csr_wdata
);
   import jdtm_pkg::*;

   logic            accept;
   logic            outstanding;
   rsp_payload_type core_rsp;
   rsp_payload_type out_rsp;

   assign accept = req_valid && req_ready;

   jdtm_dtm #(
      .ADDR_BITS (ADDR_BITS),
      .IR_BITS   (IR_BITS)
   ) u_dtm (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .kind          (req_kind),
      .tck           (req_tck),
      .tms           (req_tms),
      .tdi           (req_tdi),
      .trst          (req_trst),
      .bus_req_ready (req_req_ready),
      .bus_rsp_valid (req_rsp_valid),
      .bus_rsp_data  (req_rsp_data),
      .bus_rsp_code  (req_rsp_code),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .payload       (core_rsp),
      .outstanding   (outstanding)
   );

   jdtm_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (core_rsp),
      .push_ready (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_rsp)
   );

   assign rsp_tdo           = out_rsp.tdo;
   assign rsp_bus_req_valid = out_rsp.bus_req_valid;
   assign rsp_bus_req_addr  = out_rsp.bus_req_addr;
   assign rsp_bus_req_op    = out_rsp.bus_req_op;
   assign rsp_bus_req_data  = out_rsp.bus_req_data;
   assign rsp_bus_rsp_ready = out_rsp.bus_rsp_ready;
   assign rsp_debug_reset_n = out_rsp.debug_reset_n;
   assign rsp_command_done  = out_rsp.command_done;
   assign rsp_accepting     = out_rsp.accepting;

   // held pin or reset request does nothing
   assert property (@(posedge clock) disable iff (reset)
      accept && outstanding && (req_kind == KIND_PIN || req_kind == KIND_RESET)
      |-> !core_rsp.command_done && !core_rsp.accepting)
      else $error("held request changed command state");

   // an empty result register means the skid entry is empty too
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("skid entry occupied with empty result register");

   // outstanding only rises from an issued dmi request
   assert property (@(posedge clock) disable iff (reset)
      $rose(outstanding)
      |-> $past(accept && core_rsp.command_done && core_rsp.bus_req_valid))
      else $error("outstanding set without an issued request");

endmodule

`default_nettype wire

// File: bench/jdtm_checker.sv
// jdtm_checker: predicts every result of the jtag debug transport module from the requests it
// accepts and compares them in order with the results it gives; depends on jdtm_pkg only
`default_nettype none

module jdtm_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire logic [1:0]                     req_kind,
   input  wire logic                           req_tck,
   input  wire logic                           req_tms,
   input  wire logic                           req_tdi,
   input  wire logic                           req_trst,
   input  wire logic                           req_req_ready,
   input  wire logic                           req_rsp_valid,
   input  wire logic [jdtm_pkg::DATA_W-1:0]    req_rsp_data,
   input  wire logic [1:0]                     req_rsp_code,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire logic                           rsp_tdo,
   input  wire logic                           rsp_bus_req_valid,
   input  wire logic [jdtm_pkg::OUT_ADDR_W-1:0] rsp_bus_req_addr,
   input  wire logic [1:0]                     rsp_bus_req_op,
   input  wire logic [jdtm_pkg::DATA_W-1:0]    rsp_bus_req_data,
   input  wire logic                           rsp_bus_rsp_ready,
   input  wire logic                           rsp_debug_reset_n,
   input  wire logic                           rsp_command_done,
   input  wire logic                           rsp_accepting,
   input  wire logic                           csr_write_en,
   input  wire logic [jdtm_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [jdtm_pkg::DATA_W-1:0]    csr_wdata,
   output int                                  results_due_count,
   output int                                  mismatch_count
);
   import jdtm_pkg::*;

   localparam int ADDR_W = ADDR_BITS_DEFAULT;
   localparam int IR_W   = IR_BITS_DEFAULT;
   localparam int DMI_W  = 34 + ADDR_W;

   tap_state_type     tap;
   logic [IR_W-1:0]   ir_shift;
   logic [IR_W-1:0]   ir_current;
   logic [DMI_W-1:0]  dr_shift;
   logic [DMI_W-1:0]  dr_update;
   int unsigned       dr_len;
   logic              tdo_q;
   logic              outstanding;
   logic              bus_valid_q;
   logic [ADDR_W-1:0] bus_addr_q;
   logic [1:0]        bus_op_q;
   logic [DATA_W-1:0] bus_data_q;
   logic              reset_n_q;
   logic [DATA_W-1:0] idcode_q;
   logic [DATA_W-1:0] dtmcs_q;
   rsp_payload_type   results_due[$];
   int                errors = 0;

   task automatic advance_tap(input logic tck, input logic tms, input logic tdi,
                              output logic done);
      logic [63:0] wide;
      done = 1'b0;
      if (!tck) begin
         tdo_q = (tap == TAP_SHDR) ? dr_shift[0] : ir_shift[0];
      end else begin
         case (tap)
            TAP_TLR: begin
               reset_n_q = 1'b0;
               ir_current = INS_IDCODE[IR_W-1:0];
               if (!tms) tap = TAP_RTI;
               done = 1'b1;
            end
            TAP_RTI: begin
               reset_n_q = 1'b1;
               if (tms) tap = TAP_SELDR;
            end
            TAP_SELDR: begin
               if (tms) tap = TAP_SELIR;
               else tap = TAP_CAPDR;
            end
            TAP_CAPDR: begin
               if (ir_current == INS_IDCODE[IR_W-1:0]) begin
                  dr_shift = DMI_W'(idcode_q);
                  dr_len = 32;
               end else if (ir_current == INS_DTMCS[IR_W-1:0]) begin
                  dr_shift = DMI_W'(dtmcs_q);
                  dr_len = 32;
               end else if (ir_current == INS_DMI[IR_W-1:0]) begin
                  dr_shift = dr_update;
                  dr_len = DMI_W;
               end else begin
                  dr_shift = '0;
                  dr_len = 1;
               end
               if (tms) tap = TAP_EX1DR;
               else tap = TAP_SHDR;
            end
            TAP_SHDR: begin
               // new bit enters just above the selected register, then all move down
               wide = 64'(dr_shift);
               if (dr_len < 64) wide = wide | (64'(tdi) << dr_len);
               dr_shift = wide[DMI_W:1];
               if (tms) tap = TAP_EX1DR;
            end
            TAP_EX1DR: begin
               if (tms) tap = TAP_UPDR;
               else tap = TAP_PDR;
            end
            TAP_PDR: begin
               if (tms) tap = TAP_EX2DR;
            end
            TAP_EX2DR: begin
               if (tms) tap = TAP_UPDR;
               else tap = TAP_SHDR;
            end
            TAP_UPDR: begin
               dr_update = dr_shift;
               if (tms) tap = TAP_SELDR;
               else tap = TAP_RTI;
               if (ir_current == INS_DMI[IR_W-1:0] && dr_update[1:0] != DMI_OP_NOP) begin
                  outstanding = 1'b1;
                  bus_valid_q = 1'b1;
                  bus_addr_q = dr_update[DMI_W-1:34];
                  bus_op_q = dr_update[1:0];
                  bus_data_q = dr_update[33:2];
                  done = 1'b1;
               end
            end
            TAP_SELIR: begin
               if (tms) tap = TAP_TLR;
               else tap = TAP_CAPIR;
            end
            TAP_CAPIR: begin
               ir_shift = IR_CAPTURE[IR_W-1:0];
               if (tms) tap = TAP_EX1IR;
               else tap = TAP_SHIR;
            end
            TAP_SHIR: begin
               ir_shift = {tdi, ir_shift[IR_W-1:1]};
               if (tms) tap = TAP_EX1IR;
            end
            TAP_EX1IR: begin
               if (tms) tap = TAP_UPIR;
               else tap = TAP_PIR;
            end
            TAP_PIR: begin
               if (tms) tap = TAP_EX2IR;
            end
            TAP_EX2IR: begin
               if (tms) tap = TAP_UPIR;
               else tap = TAP_SHIR;
            end
            default: begin
               ir_current = ir_shift;
               if (tms) tap = TAP_SELDR;
               else tap = TAP_RTI;
            end
         endcase
      end
   endtask

   task automatic step_dtm();
      rsp_payload_type due;
      logic done;
      done = 1'b0;
      if (req_kind == KIND_PIN) begin
         if (!outstanding) advance_tap(req_tck, req_tms, req_tdi, done);
      end else if (req_kind == KIND_RESET) begin
         if (!outstanding) begin
            if (req_trst) begin
               reset_n_q = 1'b0;
               tap = TAP_RTI;
            end
            done = 1'b1;
         end
      end else if (req_kind == KIND_BUS) begin
         if (req_req_ready) bus_valid_q = 1'b0;
         if (req_rsp_valid) begin
            dr_update = DMI_W'({req_rsp_data, req_rsp_code});
            outstanding = 1'b0;
         end
      end
      due.tdo = tdo_q;
      due.bus_req_valid = bus_valid_q;
      due.bus_req_addr = OUT_ADDR_W'(bus_addr_q);
      due.bus_req_op = bus_op_q;
      due.bus_req_data = bus_data_q;
      due.bus_rsp_ready = 1'b1;
      due.debug_reset_n = reset_n_q;
      due.command_done = done;
      due.accepting = !outstanding;
      results_due.push_back(due);
   endtask

   task automatic check_field(input string field_name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= 10)
            $display("%0t: mismatch on %s, expected %h, actual %h", $time, field_name, want, got);
      end
   endtask

   task automatic compare_result();
      rsp_payload_type want;
      if (results_due.size() == 0) begin
         errors++;
         if (errors <= 10) $display("%0t: result with no request waiting for it", $time);
      end else begin
         want = results_due.pop_front();
         check_field("tdo", DATA_W'(want.tdo), DATA_W'(rsp_tdo));
         check_field("bus_req_valid", DATA_W'(want.bus_req_valid),
                     DATA_W'(rsp_bus_req_valid));
         check_field("bus_req_addr", DATA_W'(want.bus_req_addr), DATA_W'(rsp_bus_req_addr));
         check_field("bus_req_op", DATA_W'(want.bus_req_op), DATA_W'(rsp_bus_req_op));
         check_field("bus_req_data", want.bus_req_data, rsp_bus_req_data);
         check_field("bus_rsp_ready", DATA_W'(want.bus_rsp_ready),
                     DATA_W'(rsp_bus_rsp_ready));
         check_field("debug_reset_n", DATA_W'(want.debug_reset_n),
                     DATA_W'(rsp_debug_reset_n));
         check_field("command_done", DATA_W'(want.command_done), DATA_W'(rsp_command_done));
         check_field("accepting", DATA_W'(want.accepting), DATA_W'(rsp_accepting));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tap = TAP_TLR;
         ir_shift = '0;
         ir_current = '0;
         dr_shift = '0;
         dr_update = '0;
         dr_len = 0;
         tdo_q = 1'b0;
         outstanding = 1'b0;
         bus_valid_q = 1'b0;
         bus_addr_q = '0;
         bus_op_q = '0;
         bus_data_q = '0;
         reset_n_q = 1'b0;
         idcode_q = IDCODE_RESET;
         dtmcs_q = DTMCS_RESET;
         results_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) compare_result();
         if (csr_write_en) begin
            if (csr_index == CSR_IDCODE) idcode_q = csr_wdata;
            else if (csr_index == CSR_DTMCS) dtmcs_q = csr_wdata;
         end
         if (req_valid && req_ready) step_dtm();
      end
      results_due_count <= results_due.size();
      mismatch_count <= errors;
   end

endmodule

`default_nettype wire

// File: bench/tb_jtag_debug_transport_module.sv
// tb_jtag_debug_transport_module: drives jtag pin, test-reset and debug bus requests into
// the block under random stalls and gives the verdict; depends on jdtm_pkg, jdtm_checker, jtag_debug_transport_module
`default_nettype none

module tb_jtag_debug_transport_module;
   import jdtm_pkg::*;

   localparam int IR_W          = IR_BITS_DEFAULT;
   localparam int DMI_W         = 34 + ADDR_BITS_DEFAULT;
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASE_ITEMS   = 270;
   localparam int SETTLE_CYCLES = 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_kind = KIND_PIN;
   logic                  req_tck = 1'b0;
   logic                  req_tms = 1'b0;
   logic                  req_tdi = 1'b0;
   logic                  req_trst = 1'b0;
   logic                  req_req_ready = 1'b0;
   logic                  req_rsp_valid = 1'b0;
   logic [DATA_W-1:0]     req_rsp_data = '0;
   logic [1:0]            req_rsp_code = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_tdo;
   logic                  rsp_bus_req_valid;
   logic [OUT_ADDR_W-1:0] rsp_bus_req_addr;
   logic [1:0]            rsp_bus_req_op;
   logic [DATA_W-1:0]     rsp_bus_req_data;
   logic                  rsp_bus_rsp_ready;
   logic                  rsp_debug_reset_n;
   logic                  rsp_command_done;
   logic                  rsp_accepting;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [DATA_W-1:0]     csr_wdata = '0;

   int                    results_due_count;
   int                    mismatch_count;
   int                    send_idle_pct = 13;
   int                    recv_idle_pct = 61;
   int                    quiet_cycles = 0;
   int                    sent_items = 0;
   logic [IR_W-1:0]       selected_ir = '0;

   jtag_debug_transport_module dut (.*);

   jdtm_checker u_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic logic coin();
      return 1'($urandom_range(1));
   endfunction

   task automatic send_request(input kind_type kind, input logic tck, input logic tms,
                               input logic tdi, input logic trst, input logic bus_ready,
                               input logic bus_valid, input logic [DATA_W-1:0] bus_data,
                               input logic [1:0] bus_code);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_tck <= tck;
      req_tms <= tms;
      req_tdi <= tdi;
      req_trst <= trst;
      req_req_ready <= bus_ready;
      req_rsp_valid <= bus_valid;
      req_rsp_data <= bus_data;
      req_rsp_code <= bus_code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
   endtask

   task automatic jtag_pin(input logic tck, input logic tms, input logic tdi);
      send_request(KIND_PIN, tck, tms, tdi, coin(), coin(), coin(), $urandom,
                   2'($urandom_range(3)));
   endtask

   task automatic bus_sample(input logic bus_ready, input logic bus_valid);
      send_request(KIND_BUS, coin(), coin(), coin(), coin(), bus_ready, bus_valid, $urandom,
                   2'($urandom_range(3)));
   endtask

   task automatic test_reset(input logic trst);
      send_request(KIND_RESET, coin(), coin(), coin(), trst, coin(), coin(), $urandom,
                   2'($urandom_range(3)));
   endtask

   // optional tdo sample on the low phase, then the advancing high phase
   task automatic tck_cycle(input logic tms, input logic tdi);
      if ($urandom_range(99) < 35) jtag_pin(1'b0, coin(), coin());
      jtag_pin(1'b1, tms, tdi);
   endtask

   // from exit1 to update, now and then through pause and exit2
   task automatic exit_to_update();
      if ($urandom_range(3) == 0) begin
         tck_cycle(1'b0, coin());
         repeat ($urandom_range(2)) tck_cycle(1'b0, coin());
         tck_cycle(1'b1, coin());
         tck_cycle(1'b1, coin());
      end else begin
         tck_cycle(1'b1, coin());
      end
   endtask

   task automatic shift_ir(input logic [IR_W-1:0] code);
      tck_cycle(1'b1, coin());
      tck_cycle(1'b1, coin());
      tck_cycle(1'b0, coin());
      tck_cycle(1'b0, coin());
      for (int i = 0; i < IR_W; i++) tck_cycle(i == IR_W - 1, code[i]);
      exit_to_update();
      tck_cycle(1'b0, coin());
      selected_ir = code;
   endtask

   task automatic shift_dr(input int nbits, input logic [DMI_W-1:0] bits);
      tck_cycle(1'b1, coin());
      tck_cycle(1'b0, coin());
      tck_cycle(1'b0, coin());
      for (int i = 0; i < nbits; i++) tck_cycle(i == nbits - 1, bits[i]);
      exit_to_update();
      tck_cycle(1'b0, coin());
      // debug bus side: a few samples, usually closing with the response
      repeat ($urandom_range(2)) bus_sample(coin(), 1'b0);
      bus_sample(1'b1, $urandom_range(9) != 0);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_random_phase(input int items);
      int first;
      int pick;
      first = sent_items;
      while (sent_items - first < items) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            if (selected_ir != INS_DMI[IR_W-1:0]) shift_ir(INS_DMI[IR_W-1:0]);
            shift_dr(DMI_W, {7'($urandom_range(127)), 32'($urandom), 2'($urandom_range(3))});
         end else if (pick < 50) begin
            case ($urandom_range(3))
               0: shift_ir(INS_IDCODE[IR_W-1:0]);
               1: shift_ir(INS_DTMCS[IR_W-1:0]);
               2: shift_ir(INS_DMI[IR_W-1:0]);
               default: shift_ir(IR_W'($urandom_range(31)));
            endcase
         end else if (pick < 70) begin
            shift_dr($urandom_range(1, DMI_W), DMI_W'({$urandom, $urandom}));
         end else if (pick < 80) begin
            repeat (5) tck_cycle(1'b1, coin());
            tck_cycle(1'b0, coin());
            selected_ir = INS_IDCODE[IR_W-1:0];
         end else begin
            repeat ($urandom_range(1, 4))
               send_request(kind_type'($urandom_range(3)), coin(), coin(), coin(), coin(),
                            coin(), coin(), $urandom, 2'($urandom_range(3)));
            // back to run-test/idle with nothing outstanding
            bus_sample(1'b1, 1'b1);
            test_reset(1'b1);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_request(KIND_NONE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, '1, 2'd3);
      test_reset(1'b0);
      jtag_pin(1'b0, 1'b0, 1'b0);
      jtag_pin(1'b1, 1'b0, 1'b0);
      send_request(KIND_BUS, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, '1, 2'd3);
      send_request(KIND_BUS, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, '0, 2'd0);
      test_reset(1'b1);
      jtag_pin(1'b1, 1'b1, 1'b0);
      jtag_pin(1'b1, 1'b0, 1'b0);
      jtag_pin(1'b1, 1'b0, 1'b0);
      jtag_pin(1'b0, 1'b0, 1'b0);
      jtag_pin(1'b1, 1'b0, 1'b1);
      jtag_pin(1'b1, 1'b1, 1'b0);
      jtag_pin(1'b1, 1'b0, 1'b0);
      jtag_pin(1'b1, 1'b1, 1'b0);
      jtag_pin(1'b1, 1'b1, 1'b0);
      jtag_pin(1'b1, 1'b1, 1'b0);
      jtag_pin(1'b1, 1'b1, 1'b0);
      jtag_pin(1'b1, 1'b1, 1'b0);
      jtag_pin(1'b1, 1'b1, 1'b0);
      jtag_pin(1'b1, 1'b0, 1'b0);
      selected_ir = INS_IDCODE[IR_W-1:0];
      drain_results();

      write_csr(CSR_IDCODE, '1);
      write_csr(CSR_DTMCS, '0);
      run_random_phase(PHASE_ITEMS);
      drain_results();

      send_idle_pct = 61;
      recv_idle_pct = 13;
      write_csr(CSR_IDCODE, '0);
      write_csr(CSR_DTMCS, '1);
      run_random_phase(PHASE_ITEMS);
      drain_results();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_IDCODE, $urandom);
      write_csr(CSR_DTMCS, $urandom);
      run_random_phase(PHASE_ITEMS);
      drain_results();

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire
